// ===== hdl/rsct_pkg.sv =====
// Shared constants for the reception sphere capture test.
package rsct_pkg;

    // Default coordinate width (signed fixed point)
    localparam int COORD_BITS_DEF = 32;

    // Projection fraction bits produced by the divider chain
    localparam int T_BITS = 32;

    // Path length and cone slope formats
    localparam int PRIOR_W    = 32;
    localparam int SLOPE_W    = 32;
    localparam int SLOPE_FRAC = 30;

    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 32'd864900000;

endpackage

// ===== hdl/rsct_div_cell.sv =====
// One restoring division cell: produces one quotient bit per transaction.
module rsct_div_cell #(
    parameter int DD_W  = 66,
    parameter int Q_W   = 32,
    parameter int PAY_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DD_W-1:0]  in_rem,
    input  logic [DD_W-1:0]  in_dd,
    input  logic [Q_W-1:0]   in_q,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [DD_W-1:0]  out_rem,
    output logic [DD_W-1:0]  out_dd,
    output logic [Q_W-1:0]   out_q,
    output logic [PAY_W-1:0] out_pay
);

    logic             valid_reg;
    logic [DD_W-1:0]  rem_reg, rem_next;
    logic [DD_W-1:0]  dd_reg;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [PAY_W-1:0] pay_reg;

    logic [DD_W:0]    rem_sh;
    logic [DD_W:0]    rem_sub;
    logic             take;

    // Shift remainder, trial subtract divisor
    always_comb
    begin
        rem_sh   = {in_rem, 1'b0};
        rem_sub  = rem_sh - {1'b0, in_dd};
        take     = (rem_sh >= {1'b0, in_dd});
        rem_next = take ? rem_sub[DD_W-1:0] : rem_sh[DD_W-1:0];
        q_next   = {in_q[Q_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dd_reg  <= in_dd;
            q_reg   <= q_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dd    = dd_reg;
    assign out_q     = q_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== hdl/rsct_sqrt_cell.sv =====
// One digit-by-digit square root cell: produces one root bit per transaction.
module rsct_sqrt_cell #(
    parameter int R_W   = 33,
    parameter int PAY_W = 8,
    localparam int N_W   = 2 * R_W,
    localparam int REM_W = R_W + 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [N_W-1:0]   in_n,
    input  logic [REM_W-1:0] in_rem,
    input  logic [R_W-1:0]   in_root,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [N_W-1:0]   out_n,
    output logic [REM_W-1:0] out_rem,
    output logic [R_W-1:0]   out_root,
    output logic [PAY_W-1:0] out_pay
);

    logic             valid_reg;
    logic [N_W-1:0]   n_reg, n_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [R_W-1:0]   root_reg, root_next;
    logic [PAY_W-1:0] pay_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // Bring down two radicand bits, trial subtract 4*root+1
    always_comb
    begin
        rem_sh    = {in_rem[R_W:0], in_n[N_W-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[R_W-2:0], take};
        n_next    = {in_n[N_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== hdl/reception_sphere_capture_test.sv =====
// Reception sphere capture test: fully pipelined projection, divide, root and compare.
//
//  channel   dir  handshake               payload
//  in        in   in_valid / in_ready     segment start/end, receiver, prior_length
//  out       out  out_valid / out_ready   captured, capture_x/y/z, status
//  cfg       in   cfg_valid / cfg_ready   cfg_data (cone_slope, Q2.30)
//
// One transaction per cycle while the output is not stalled; a transaction passes
// the front stages, the divider cell chain (one quotient bit a cell), the offset
// stages, the square root cell chain (one root bit a cell) and the back stages.
// Reset clears all valid bits; cone_slope returns to its reset value.
// A stalled output freezes the whole pipeline; cfg_ready is always high.
module reception_sphere_capture_test #(
    parameter int COORD_BITS = rsct_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [COORD_BITS-1:0]         seg_start_x,
    input  logic [COORD_BITS-1:0]         seg_start_y,
    input  logic [COORD_BITS-1:0]         seg_start_z,
    input  logic [COORD_BITS-1:0]         seg_end_x,
    input  logic [COORD_BITS-1:0]         seg_end_y,
    input  logic [COORD_BITS-1:0]         seg_end_z,
    input  logic [COORD_BITS-1:0]         receiver_x,
    input  logic [COORD_BITS-1:0]         receiver_y,
    input  logic [COORD_BITS-1:0]         receiver_z,
    input  logic [rsct_pkg::PRIOR_W-1:0]  prior_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          captured,
    output logic [COORD_BITS-1:0]         capture_x,
    output logic [COORD_BITS-1:0]         capture_y,
    output logic [COORD_BITS-1:0]         capture_z,
    output logic                          status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsct_pkg::SLOPE_W-1:0]  cfg_data
);

    import rsct_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int DW      = CB + 1;               // coordinate differences
    localparam int PW      = 2 * DW;               // squares, dot terms, sums
    localparam int DOT_W   = PW + 2;
    localparam int MP_W    = DW + T_BITS;          // |d| * q
    localparam int UNF_W   = ((DW > PRIOR_W) ? DW : PRIOR_W) + 1;
    localparam int PRD_W   = UNF_W + SLOPE_W;
    localparam int RAD_W   = PRD_W - SLOPE_FRAC;
    localparam int LO_W    = RAD_W / 2;
    localparam int HI_W    = RAD_W - LO_W;
    localparam int RSQ_W   = 2 * RAD_W;
    localparam int CMP_W   = (RSQ_W > PW) ? RSQ_W : PW;
    localparam int DPAY_W  = 6 * CB + 3 * DW + PRIOR_W + 3;
    localparam int SPAY_W  = PW + PRIOR_W + 3 * CB + 2;
    localparam int SREM_W  = DW + 3;

    // Global advance: the output register is empty or being taken
    logic en;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Cone slope register
    logic [SLOPE_W-1:0] slope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg <= SLOPE_RESET;
        end
        else if (cfg_valid)
        begin
            slope_reg <= cfg_data;
        end
    end

    // Front stages: capture, differences, products, sums
    logic                  s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [2:0][CB-1:0]    s1_s_reg, s1_e_reg, s1_r_reg;
    logic [PRIOR_W-1:0]    s1_prior_reg, s2_prior_reg, s3_prior_reg, s4_prior_reg;
    logic [2:0][CB-1:0]    s2_s_reg, s2_r_reg, s3_s_reg, s3_r_reg, s4_s_reg, s4_r_reg;
    logic [2:0][DW-1:0]    s2_d_reg, s2_w_reg, s3_d_reg, s4_d_reg;
    logic [2:0][PW-1:0]    s3_pdd_reg, s3_pdot_reg;
    logic [PW-1:0]         s4_dd_reg;
    logic [DOT_W-1:0]      s4_dot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_s_reg     <= {seg_start_z, seg_start_y, seg_start_x};
            s1_e_reg     <= {seg_end_z, seg_end_y, seg_end_x};
            s1_r_reg     <= {receiver_z, receiver_y, receiver_x};
            s1_prior_reg <= prior_length;

            for (int i = 0; i < 3; i++)
            begin
                s2_d_reg[i] <= {s1_e_reg[i][CB-1], s1_e_reg[i]}
                             - {s1_s_reg[i][CB-1], s1_s_reg[i]};
                s2_w_reg[i] <= {s1_r_reg[i][CB-1], s1_r_reg[i]}
                             - {s1_s_reg[i][CB-1], s1_s_reg[i]};
                s3_pdd_reg[i]  <= PW'($signed(s2_d_reg[i])) * PW'($signed(s2_d_reg[i]));
                s3_pdot_reg[i] <= PW'($signed(s2_d_reg[i])) * PW'($signed(s2_w_reg[i]));
            end
            s2_s_reg     <= s1_s_reg;
            s2_r_reg     <= s1_r_reg;
            s2_prior_reg <= s1_prior_reg;

            s3_s_reg     <= s2_s_reg;
            s3_d_reg     <= s2_d_reg;
            s3_r_reg     <= s2_r_reg;
            s3_prior_reg <= s2_prior_reg;

            s4_dd_reg    <= s3_pdd_reg[0] + s3_pdd_reg[1] + s3_pdd_reg[2];
            s4_dot_reg   <= DOT_W'($signed(s3_pdot_reg[0])) + DOT_W'($signed(s3_pdot_reg[1]))
                          + DOT_W'($signed(s3_pdot_reg[2]));
            s4_s_reg     <= s3_s_reg;
            s4_d_reg     <= s3_d_reg;
            s4_r_reg     <= s3_r_reg;
            s4_prior_reg <= s3_prior_reg;
        end
    end

    // Case split at the divider entry
    logic          f_zero, f_behind, f_beyond, f_mid;
    logic [PW-1:0] div_rem0;

    always_comb
    begin
        f_zero   = (s4_dd_reg == '0);
        f_behind = s4_dot_reg[DOT_W-1];
        f_beyond = !f_behind && (s4_dot_reg >= {2'b00, s4_dd_reg});
        f_mid    = !f_zero && !f_behind && !f_beyond;
        div_rem0 = f_mid ? s4_dot_reg[PW-1:0] : '0;
    end

    // Divider cell chain: q = floor(dot * 2^T_BITS / dd)
    logic                dv_v   [0:T_BITS];
    logic [PW-1:0]       dv_rem [0:T_BITS];
    logic [PW-1:0]       dv_dd  [0:T_BITS];
    logic [T_BITS-1:0]   dv_q   [0:T_BITS];
    logic [DPAY_W-1:0]   dv_pay [0:T_BITS];

    assign dv_v[0]   = s4_v_reg;
    assign dv_rem[0] = div_rem0;
    assign dv_dd[0]  = s4_dd_reg;
    assign dv_q[0]   = '0;
    assign dv_pay[0] = {s4_s_reg, s4_d_reg, s4_r_reg, s4_prior_reg,
                        f_zero, f_behind, f_beyond};

    for (genvar k = 0; k < T_BITS; k++)
    begin : g_div
        rsct_div_cell #(
            .DD_W  (PW),
            .Q_W   (T_BITS),
            .PAY_W (DPAY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[k]),
            .in_rem    (dv_rem[k]),
            .in_dd     (dv_dd[k]),
            .in_q      (dv_q[k]),
            .in_pay    (dv_pay[k]),
            .out_valid (dv_v[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_dd    (dv_dd[k+1]),
            .out_q     (dv_q[k+1]),
            .out_pay   (dv_pay[k+1])
        );
    end

    logic [2:0][CB-1:0]  dq_s, dq_r;
    logic [2:0][DW-1:0]  dq_d;
    logic [PRIOR_W-1:0]  dq_prior;
    logic                dq_zero, dq_behind, dq_beyond;

    assign {dq_s, dq_d, dq_r, dq_prior, dq_zero, dq_behind, dq_beyond} = dv_pay[T_BITS];

    // Offset stages: scale, round, select, capture point, squares, sums
    logic                m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg, m5_v_reg;
    logic [2:0][MP_W-1:0] m1_prod_reg;
    logic [2:0][CB-1:0]  m1_s_reg, m1_r_reg, m2_r_reg, m2_p_reg, m3_p_reg, m4_p_reg, m5_p_reg;
    logic [2:0][DW-1:0]  m1_d_reg, m2_off_reg, m3_off_reg, m3_rp_reg;
    logic [PRIOR_W-1:0]  m1_prior_reg, m2_prior_reg, m3_prior_reg, m4_prior_reg, m5_prior_reg;
    logic                m1_zero_reg, m1_behind_reg, m1_beyond_reg;
    logic                m2_zero_reg, m3_zero_reg, m4_zero_reg, m5_zero_reg;
    logic                m2_act_reg, m3_act_reg, m4_act_reg, m5_act_reg;
    logic [2:0][PW-1:0]  m4_sqo_reg, m4_sqr_reg;
    logic [PW-1:0]       m5_lsq_reg, m5_dist2_reg;

    logic [2:0][DW-1:0]  mag_d;
    logic [2:0][MP_W-1:0] rnd_sum;
    logic [2:0][DW-1:0]  rnd_v, off_sel;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_d[i]   = dq_d[i][DW-1] ? (DW'(0) - dq_d[i]) : dq_d[i];
            rnd_sum[i] = m1_prod_reg[i] + (MP_W'(1) << (T_BITS - 1));
            rnd_v[i]   = rnd_sum[i][T_BITS +: DW];
            if (m1_zero_reg || m1_behind_reg)
            begin
                off_sel[i] = '0;
            end
            else if (m1_beyond_reg)
            begin
                off_sel[i] = m1_d_reg[i];
            end
            else
            begin
                off_sel[i] = m1_d_reg[i][DW-1] ? (DW'(0) - rnd_v[i]) : rnd_v[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_prod_reg[i] <= MP_W'(mag_d[i]) * MP_W'(dv_q[T_BITS]);
                m2_off_reg[i]  <= off_sel[i];
                m2_p_reg[i]    <= m1_s_reg[i] + off_sel[i][CB-1:0];
                m3_rp_reg[i]   <= {m2_r_reg[i][CB-1], m2_r_reg[i]}
                                - {m2_p_reg[i][CB-1], m2_p_reg[i]};
                m4_sqo_reg[i]  <= PW'($signed(m3_off_reg[i])) * PW'($signed(m3_off_reg[i]));
                m4_sqr_reg[i]  <= PW'($signed(m3_rp_reg[i])) * PW'($signed(m3_rp_reg[i]));
            end
            m1_s_reg      <= dq_s;
            m1_d_reg      <= dq_d;
            m1_r_reg      <= dq_r;
            m1_prior_reg  <= dq_prior;
            m1_zero_reg   <= dq_zero;
            m1_behind_reg <= dq_behind;
            m1_beyond_reg <= dq_beyond;

            m2_r_reg      <= m1_r_reg;
            m2_prior_reg  <= m1_prior_reg;
            m2_zero_reg   <= m1_zero_reg;
            m2_act_reg    <= !m1_zero_reg && !m1_behind_reg;

            m3_off_reg    <= m2_off_reg;
            m3_p_reg      <= m2_p_reg;
            m3_prior_reg  <= m2_prior_reg;
            m3_zero_reg   <= m2_zero_reg;
            m3_act_reg    <= m2_act_reg;

            m4_p_reg      <= m3_p_reg;
            m4_prior_reg  <= m3_prior_reg;
            m4_zero_reg   <= m3_zero_reg;
            m4_act_reg    <= m3_act_reg;

            m5_lsq_reg    <= m4_sqo_reg[0] + m4_sqo_reg[1] + m4_sqo_reg[2];
            m5_dist2_reg  <= m4_sqr_reg[0] + m4_sqr_reg[1] + m4_sqr_reg[2];
            m5_p_reg      <= m4_p_reg;
            m5_prior_reg  <= m4_prior_reg;
            m5_zero_reg   <= m4_zero_reg;
            m5_act_reg    <= m4_act_reg;
        end
    end

    // Square root cell chain: floor(sqrt(|P - S|^2))
    logic                sq_v    [0:DW];
    logic [PW-1:0]       sq_n    [0:DW];
    logic [SREM_W-1:0]   sq_rem  [0:DW];
    logic [DW-1:0]       sq_root [0:DW];
    logic [SPAY_W-1:0]   sq_pay  [0:DW];

    assign sq_v[0]    = m5_v_reg;
    assign sq_n[0]    = m5_lsq_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pay[0]  = {m5_dist2_reg, m5_prior_reg, m5_p_reg, m5_zero_reg, m5_act_reg};

    for (genvar k = 0; k < DW; k++)
    begin : g_sqrt
        rsct_sqrt_cell #(
            .R_W   (DW),
            .PAY_W (SPAY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[k]),
            .in_n      (sq_n[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_pay    (sq_pay[k]),
            .out_valid (sq_v[k+1]),
            .out_n     (sq_n[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_pay   (sq_pay[k+1])
        );
    end

    logic [PW-1:0]       rq_dist2;
    logic [PRIOR_W-1:0]  rq_prior;
    logic [2:0][CB-1:0]  rq_p;
    logic                rq_zero, rq_act;

    assign {rq_dist2, rq_prior, rq_p, rq_zero, rq_act} = sq_pay[DW];

    // Back stages: unfolded length, radius, radius squared, compare
    logic                u_v_reg, r_v_reg, q1_v_reg, q2_v_reg, o_v_reg;
    logic [UNF_W-1:0]    u_unf_reg;
    logic [RAD_W-1:0]    r_rad_reg;
    logic [HI_W+RAD_W-1:0] q1_pa_reg;
    logic [LO_W+RAD_W-1:0] q1_pb_reg;
    logic [RSQ_W-1:0]    q2_rsq_reg;
    logic [PW-1:0]       u_dist2_reg, r_dist2_reg, q1_dist2_reg, q2_dist2_reg;
    logic [2:0][CB-1:0]  u_p_reg, r_p_reg, q1_p_reg, q2_p_reg, o_p_reg;
    logic                u_zero_reg, r_zero_reg, q1_zero_reg, q2_zero_reg, o_zero_reg;
    logic                u_act_reg, r_act_reg, q1_act_reg, q2_act_reg, o_cap_reg;
    logic [PRD_W-1:0]    rad_full;

    assign rad_full = PRD_W'(u_unf_reg) * PRD_W'(slope_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_unf_reg   <= UNF_W'(rq_prior) + UNF_W'(sq_root[DW]);
            u_dist2_reg <= rq_dist2;
            u_p_reg     <= rq_p;
            u_zero_reg  <= rq_zero;
            u_act_reg   <= rq_act;

            r_rad_reg   <= rad_full[SLOPE_FRAC +: RAD_W];
            r_dist2_reg <= u_dist2_reg;
            r_p_reg     <= u_p_reg;
            r_zero_reg  <= u_zero_reg;
            r_act_reg   <= u_act_reg;

            q1_pa_reg    <= (HI_W+RAD_W)'(r_rad_reg[RAD_W-1:LO_W]) * (HI_W+RAD_W)'(r_rad_reg);
            q1_pb_reg    <= (LO_W+RAD_W)'(r_rad_reg[LO_W-1:0]) * (LO_W+RAD_W)'(r_rad_reg);
            q1_dist2_reg <= r_dist2_reg;
            q1_p_reg     <= r_p_reg;
            q1_zero_reg  <= r_zero_reg;
            q1_act_reg   <= r_act_reg;

            q2_rsq_reg   <= (RSQ_W'(q1_pa_reg) << LO_W) + RSQ_W'(q1_pb_reg);
            q2_dist2_reg <= q1_dist2_reg;
            q2_p_reg     <= q1_p_reg;
            q2_zero_reg  <= q1_zero_reg;
            q2_act_reg   <= q1_act_reg;

            o_cap_reg    <= q2_act_reg && (CMP_W'(q2_rsq_reg) >= CMP_W'(q2_dist2_reg));
            o_p_reg      <= q2_p_reg;
            o_zero_reg   <= q2_zero_reg;
        end
    end

    // Valid bits of the non-cell stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            m4_v_reg <= 1'b0;
            m5_v_reg <= 1'b0;
            u_v_reg  <= 1'b0;
            r_v_reg  <= 1'b0;
            q1_v_reg <= 1'b0;
            q2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            m1_v_reg <= dv_v[T_BITS];
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            m4_v_reg <= m3_v_reg;
            m5_v_reg <= m4_v_reg;
            u_v_reg  <= sq_v[DW];
            r_v_reg  <= u_v_reg;
            q1_v_reg <= r_v_reg;
            q2_v_reg <= q1_v_reg;
            o_v_reg  <= q2_v_reg;
        end
    end

    // Result transaction
    assign out_valid = o_v_reg;
    assign captured  = o_cap_reg;
    assign capture_x = o_p_reg[0];
    assign capture_y = o_p_reg[1];
    assign capture_z = o_p_reg[2];
    assign status    = o_zero_reg;

endmodule
